@@ hdl/mer_pkg.sv @@
// shared types and defaults for the midpoint ellipse rasterizer
// no dependencies; imported by mer_out and the top module
`default_nettype none

package mer_pkg;

    localparam int RADIUS_BITS_DEF = 10;
    localparam int COORD_BITS_DEF  = 11;

    // input kind carried in s_axis_tuser
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    typedef enum logic [1:0] {
        REG_ONE  = 2'd0,
        REG_TWO  = 2'd1,
        REG_DONE = 2'd2
    } t_region;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MRX,
        ST_MRY,
        ST_MRXY,
        ST_MK,
        ST_MKW,
        ST_ADV1,
        ST_ADV2,
        ST_ADV3,
        ST_EMIT,
        ST_FIN,
        ST_SETTLE,
        ST_Z1,
        ST_Z2,
        ST_Z3,
        ST_Z4,
        ST_Z5
    } t_state;

    typedef struct packed {
        logic finished;
        logic last;
        logic pixel_valid;
    } t_beat_flags;

endpackage

`default_nettype wire

@@ hdl/mer_mul.sv @@
// shared unsigned multiplier with a registered product
// no package dependencies
`default_nettype none

module mer_mul #(
    parameter int A_W = 32,
    parameter int B_W = 12
) (
    input  logic                 i_clk,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    output logic [A_W+B_W-1:0]   o_prod
);

    logic [A_W+B_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ hdl/mer_out.sv @@
// output register for result beats on the master stream side
// depends on mer_pkg for the beat flag struct
`default_nettype none

module mer_out #(
    parameter int DATA_W = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  mer_pkg::t_beat_flags  i_flags,
    input  logic [DATA_W-1:0]     i_data,
    output logic                  o_room,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [DATA_W-1:0]     o_m_tdata,
    output logic                  o_m_tlast,
    output logic [1:0]            o_m_tuser
);
    import mer_pkg::*;

    logic              r_valid;
    logic [DATA_W-1:0] r_data;
    t_beat_flags       r_flags;

    assign o_room = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_room && i_load) begin
            r_data  <= i_data;
            r_flags <= i_flags;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_flags.last;
    assign o_m_tuser  = {r_flags.finished, r_flags.pixel_valid};

endmodule

`default_nettype wire

@@ hdl/midpoint_ellipse_rasterizer.sv @@
// start beat: accept, MRX, MRY, MRXY, MK, MKW setup on the shared multiplier, 4 beats, settle
// advance beat: ADV1-ADV3 updates, 4 beats, settle; Z1-Z5 and a second settle open region 2
// advance after completion: FIN, one beat; one item in flight, ready only when idle
// output register lets the last beat wait while the next item is taken
// synchronous active-low reset: ellipse finished, output empty, no clearing pass
`default_nettype none

module midpoint_ellipse_rasterizer #(
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // slave side
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // center_x, center_y, radius_x, radius_y, pen_color (lowest first), zero padded
    input  logic [((2*COORD_BITS+2*RADIUS_BITS+4+7)/8)*8-1:0] s_axis_tdata,
    // mode: start or advance
    input  logic s_axis_tuser,
    // master side
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // pixel_x, pixel_y, pixel_color (lowest first), zero padded
    output logic [((2*COORD_BITS+8+7)/8)*8-1:0] m_axis_tdata,
    // last_of_step
    output logic m_axis_tlast,
    // pixel_valid, finished (lowest first)
    output logic [1:0] m_axis_tuser
);
    import mer_pkg::*;

    localparam int R      = RADIUS_BITS;
    localparam int C      = COORD_BITS;
    localparam int X_W    = R + 1;         // x may run one past the radius
    localparam int SQ_W   = 2 * R;
    localparam int CR_W   = 3 * R + 2;
    localparam int K_W    = 4 * R;
    localparam int MA_W   = 3 * R + 2;
    localparam int MB_W   = R + 2;
    localparam int MP_W   = MA_W + MB_W;
    localparam int DEC_W  = 4 * R + 6;
    localparam int TERM_W = CR_W + 2;
    localparam int PIX_W  = C + 2;
    localparam int SUM_W  = (X_W > PIX_W) ? X_W : PIX_W;
    localparam int OUT_W  = ((2 * PIX_W + 4 + 7) / 8) * 8;

    // ---------------------------------------------------------------
    // input field split
    // ---------------------------------------------------------------
    logic [C-1:0] w_in_cx, w_in_cy;
    logic [R-1:0] w_in_rx, w_in_ry;
    logic [3:0]   w_in_color;
    logic         w_acc;

    assign w_in_cx    = s_axis_tdata[C-1:0];
    assign w_in_cy    = s_axis_tdata[2*C-1:C];
    assign w_in_rx    = s_axis_tdata[2*C+R-1:2*C];
    assign w_in_ry    = s_axis_tdata[2*C+2*R-1:2*C+R];
    assign w_in_color = s_axis_tdata[2*C+2*R+3:2*C+2*R];

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    t_state              r_state, n_state;
    t_region             r_region;
    logic [C-1:0]        r_cx, r_cy;
    logic [3:0]          r_color;
    logic [R-1:0]        r_rx, r_ry;
    logic [SQ_W-1:0]     r_rx2, r_ry2;
    logic [X_W-1:0]      r_x;
    logic [R-1:0]        r_y;
    logic [CR_W-1:0]     r_cross_x, r_cross_y;
    logic signed [DEC_W-1:0]  r_dec;
    logic [K_W-1:0]      r_k;       // rx^2 * ry^2
    logic [MA_W-1:0]     r_tmp;     // partial product of region 2 setup
    logic signed [TERM_W-1:0] r_term;
    logic                r_flag;    // region 1: decision was negative, region 2: y-only step
    logic [1:0]          r_cnt;

    // ---------------------------------------------------------------
    // shared multiplier and its operand select
    // ---------------------------------------------------------------
    logic [MA_W-1:0] w_mul_a;
    logic [MB_W-1:0] w_mul_b;
    logic [MP_W-1:0] w_prod;
    logic [MB_W-1:0] w_a2;   // 2x + 1
    logic [MB_W-1:0] w_b2;   // y - 1, held at 1 when y is zero

    assign w_a2 = {r_x, 1'b1};
    assign w_b2 = (r_y == '0) ? MB_W'(1) : MB_W'(r_y - R'(1));

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_MRX: begin
                w_mul_a = MA_W'(r_rx);
                w_mul_b = MB_W'(r_rx);
            end
            ST_MRY: begin
                w_mul_a = MA_W'(r_ry);
                w_mul_b = MB_W'(r_ry);
            end
            ST_MRXY: begin
                w_mul_a = MA_W'(r_rx2);
                w_mul_b = MB_W'(r_ry);
            end
            ST_MK: begin
                // (rx^2 * ry) * ry
                w_mul_a = MA_W'(w_prod);
                w_mul_b = MB_W'(r_ry);
            end
            ST_Z1: begin
                w_mul_a = MA_W'(r_ry2);
                w_mul_b = w_a2;
            end
            ST_Z2: begin
                w_mul_a = MA_W'(r_rx2);
                w_mul_b = w_b2;
            end
            ST_Z3: begin
                w_mul_a = r_tmp;
                w_mul_b = w_a2;
            end
            ST_Z4: begin
                w_mul_a = r_tmp;
                w_mul_b = w_b2;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    mer_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // ---------------------------------------------------------------
    // symmetric points, coordinates wrap to the pixel width
    // ---------------------------------------------------------------
    logic [PIX_W-1:0] w_px_p, w_px_m, w_py_p, w_py_m;

    assign w_px_p = PIX_W'(SUM_W'(r_cx) + SUM_W'(r_x));
    assign w_px_m = PIX_W'(SUM_W'(r_cx) - SUM_W'(r_x));
    assign w_py_p = PIX_W'(SUM_W'(r_cy) + SUM_W'(r_y));
    assign w_py_m = PIX_W'(SUM_W'(r_cy) - SUM_W'(r_y));

    // ---------------------------------------------------------------
    // sequencer: next state and beat loading
    // ---------------------------------------------------------------
    logic             w_room;
    logic             w_load;
    t_beat_flags      w_flags;
    logic [OUT_W-1:0] w_data;
    logic             w_cross;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_cross       = (r_cross_x >= r_cross_y);

    always_comb begin
        n_state = r_state;
        w_load  = 1'b0;
        w_flags = '0;
        w_data  = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (s_axis_tuser == MODE_START) begin
                        n_state = ST_MRX;
                    end else if (r_region == REG_DONE) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_ADV1;
                    end
                end
            end
            ST_MRX:  n_state = ST_MRY;
            ST_MRY:  n_state = ST_MRXY;
            ST_MRXY: n_state = ST_MK;
            ST_MK:   n_state = ST_MKW;
            ST_MKW:  n_state = ST_EMIT;
            ST_ADV1: n_state = ST_ADV2;
            ST_ADV2: n_state = ST_ADV3;
            ST_ADV3: n_state = ST_EMIT;
            ST_EMIT: begin
                w_load              = w_room;
                w_flags.pixel_valid = 1'b1;
                w_flags.last        = (r_cnt == 2'd3);
                case (r_cnt)
                    2'd0:    w_data = OUT_W'({r_color, w_py_p, w_px_p});
                    2'd1:    w_data = OUT_W'({r_color, w_py_p, w_px_m});
                    2'd2:    w_data = OUT_W'({r_color, w_py_m, w_px_p});
                    default: w_data = OUT_W'({r_color, w_py_m, w_px_m});
                endcase
                if (w_room && r_cnt == 2'd3) begin
                    n_state = ST_SETTLE;
                end
            end
            ST_FIN: begin
                // already complete: one empty beat, state untouched
                w_load           = w_room;
                w_flags.last     = 1'b1;
                w_flags.finished = 1'b1;
                if (w_room) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SETTLE: begin
                if (r_region == REG_ONE && w_cross) begin
                    n_state = ST_Z1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_Z1: n_state = ST_Z2;
            ST_Z2: n_state = ST_Z3;
            ST_Z3: n_state = ST_Z4;
            ST_Z4: n_state = ST_Z5;
            ST_Z5: n_state = ST_SETTLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region <= REG_DONE;
            r_cnt    <= '0;
            r_x      <= '0;
            r_y      <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (w_acc && s_axis_tuser == MODE_START) begin
                        r_region <= REG_ONE;
                        r_x      <= '0;
                        r_y      <= w_in_ry;
                    end
                end
                ST_ADV1: begin
                    if (r_region == REG_ONE) begin
                        // x always grows, y drops on a non-negative decision
                        r_x <= r_x + X_W'(1);
                        if (!r_dec[DEC_W-1]) begin
                            r_y <= r_y - R'(1);
                        end
                    end else begin
                        // y always drops, x grows unless decision is positive
                        r_y <= r_y - R'(1);
                        if (!(!r_dec[DEC_W-1] && r_dec != '0)) begin
                            r_x <= r_x + X_W'(1);
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_room) begin
                        r_cnt <= r_cnt + 2'd1;
                    end
                end
                ST_SETTLE: begin
                    if (r_region == REG_TWO && r_y == '0) begin
                        r_region <= REG_DONE;
                    end
                end
                ST_Z5: r_region <= REG_TWO;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // arithmetic registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_acc && s_axis_tuser == MODE_START) begin
                    r_cx      <= w_in_cx;
                    r_cy      <= w_in_cy;
                    r_color   <= w_in_color;
                    r_rx      <= w_in_rx;
                    r_ry      <= w_in_ry;
                    r_cross_x <= '0;
                end
            end
            ST_MRY:  r_rx2 <= SQ_W'(w_prod);
            ST_MRXY: r_ry2 <= SQ_W'(w_prod);
            ST_MK: begin
                // cross_y = 2 rx^2 ry, decision = 4 ry^2 - 4 rx^2 ry + rx^2
                r_cross_y <= {w_prod[CR_W-2:0], 1'b0};
                r_dec     <= DEC_W'({r_ry2, 2'b00}) - DEC_W'({w_prod, 2'b00})
                           + DEC_W'(r_rx2);
            end
            ST_MKW: r_k <= K_W'(w_prod);
            ST_ADV1: begin
                if (r_region == REG_ONE) begin
                    r_flag    <= r_dec[DEC_W-1];
                    r_cross_x <= r_cross_x + CR_W'({r_ry2, 1'b0});
                    if (!r_dec[DEC_W-1]) begin
                        r_cross_y <= r_cross_y - CR_W'({r_rx2, 1'b0});
                    end
                end else begin
                    r_flag    <= !r_dec[DEC_W-1] && r_dec != '0;
                    r_cross_y <= r_cross_y - CR_W'({r_rx2, 1'b0});
                    if (!(!r_dec[DEC_W-1] && r_dec != '0)) begin
                        r_cross_x <= r_cross_x + CR_W'({r_ry2, 1'b0});
                    end
                end
            end
            ST_ADV2: begin
                if (r_region == REG_ONE) begin
                    r_term <= TERM_W'(r_ry2) + TERM_W'(r_cross_x)
                            - (r_flag ? TERM_W'(0) : TERM_W'(r_cross_y));
                end else begin
                    r_term <= TERM_W'(r_rx2) - TERM_W'(r_cross_y)
                            + (r_flag ? TERM_W'(0) : TERM_W'(r_cross_x));
                end
            end
            ST_ADV3: r_dec <= r_dec + (DEC_W'(r_term) <<< 2);
            // region 2 setup:
            // ry^2 (2x+1)^2 + 4 rx^2 (y-1)^2 - 4 rx^2 ry^2
            ST_Z2: r_tmp <= MA_W'(w_prod);
            ST_Z3: r_tmp <= MA_W'(w_prod);
            ST_Z4: r_dec <= DEC_W'(w_prod) - DEC_W'({r_k, 2'b00});
            ST_Z5: r_dec <= r_dec + DEC_W'({w_prod, 2'b00});
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    mer_out #(
        .DATA_W (OUT_W)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_load),
        .i_flags    (w_flags),
        .i_data     (w_data),
        .o_room     (w_room),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .o_m_tuser  (m_axis_tuser)
    );

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_done_at_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_region == REG_DONE |-> r_y == '0)
        else $error("ellipse marked finished with y not zero");

    a_region1_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_region == REG_ONE) |-> r_cross_x < r_cross_y)
        else $error("region 1 left open past the crossing point");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_state != ST_IDLE)
        else $error("sequencer stayed idle after an accepted beat");

    a_finished_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (!m_axis_tuser[0] && m_axis_tlast))
        else $error("finished beat carries a pixel or is not last");

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// self-checking testbench for midpoint_ellipse_rasterizer: directed and random
// start/advance beats, each output pixel beat checked against an in-line model
// depends on hdl/mer_pkg.sv and hdl/midpoint_ellipse_rasterizer.sv
`timescale 1ns / 1ps

module testbench;
    import mer_pkg::*;

    // cycles with no beat on either side before the run is declared hung
    localparam int STALL_LIMIT = 2000;
    // quiet cycles after the last expected beat, well past the block latency
    localparam int DRAIN_CYCLES = 40;
    // reset length in clock cycles
    localparam int RESET_CYCLES = 11;

    // one input command for the rasterizer
    typedef struct {
        logic        mode;
        logic [10:0] center_x;
        logic [10:0] center_y;
        logic [9:0]  radius_x;
        logic [9:0]  radius_y;
        logic [3:0]  pen_color;
        bit          wait_empty;   // hold this beat until no pixel is outstanding
    } t_ellipse_cmd;

    // one output pixel beat
    typedef struct packed {
        logic [12:0] pixel_x;
        logic [12:0] pixel_y;
        logic [3:0]  pixel_color;
        logic        pixel_valid;
        logic        last_of_step;
        logic        finished;
    } t_pixel_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    t_ellipse_cmd cmd_queue[$];       // commands not yet offered
    t_pixel_beat  expected_pixels[$]; // predicted beats not yet seen
    t_ellipse_cmd active_cmd;         // command currently offered on the slave side
    int           mismatch_count = 0;
    int           idle_cycles = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           ready_left = 0;

    // model state of the rasterizer
    t_region     trace_region = REG_DONE;
    logic [31:0] cur_x = '0;
    logic [31:0] cur_y = '0;
    logic [63:0] cross_x = '0;
    logic [63:0] cross_y = '0;
    logic [63:0] decision = '0;
    logic [63:0] rx_sq = '0;
    logic [63:0] ry_sq = '0;
    logic [10:0] center_x_q = '0;
    logic [10:0] center_y_q = '0;
    logic [3:0]  color_q = '0;

    midpoint_ellipse_rasterizer u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .s_axis_tvalid         (s_axis_tvalid),
        .s_axis_tready         (s_axis_tready),
        .s_axis_tdata          (s_axis_tdata),
        .s_axis_tuser          (s_axis_tuser),
        .m_axis_tvalid         (m_axis_tvalid),
        .m_axis_tready         (m_axis_tready),
        .m_axis_tdata          (m_axis_tdata),
        .m_axis_tlast          (m_axis_tlast),
        .m_axis_tuser          (m_axis_tuser)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // pixel prediction
    // ------------------------------------------------------------------

    // four symmetric points in output order, last flag on the fourth
    task automatic emit_quad();
        logic [31:0] x_pos, x_neg, y_pos, y_neg;
        t_pixel_beat pb;
        x_pos = 32'(center_x_q) + cur_x;
        x_neg = 32'(center_x_q) - cur_x;
        y_pos = 32'(center_y_q) + cur_y;
        y_neg = 32'(center_y_q) - cur_y;
        pb.pixel_color  = color_q;
        pb.pixel_valid  = 1'b1;
        pb.finished     = 1'b0;
        pb.last_of_step = 1'b0;
        pb.pixel_x = x_pos[12:0]; pb.pixel_y = y_pos[12:0]; expected_pixels.push_back(pb);
        pb.pixel_x = x_neg[12:0]; pb.pixel_y = y_pos[12:0]; expected_pixels.push_back(pb);
        pb.pixel_x = x_pos[12:0]; pb.pixel_y = y_neg[12:0]; expected_pixels.push_back(pb);
        pb.last_of_step = 1'b1;
        pb.pixel_x = x_neg[12:0]; pb.pixel_y = y_neg[12:0]; expected_pixels.push_back(pb);
    endtask

    // region 1 ends once the x gradient term catches up with the y term;
    // region 2 decision restarts from the current point, scaled by 4
    task automatic settle_region();
        logic [63:0] a_term, b_term;
        if (trace_region == REG_ONE && cross_x >= cross_y) begin
            a_term   = 2 * {32'b0, cur_x} + 1;
            b_term   = (cur_y == 0) ? 64'd1 : {32'b0, cur_y} - 1;
            decision = ry_sq * a_term * a_term + 4 * rx_sq * b_term * b_term
                     - 4 * rx_sq * ry_sq;
            trace_region = REG_TWO;
        end
        if (trace_region == REG_TWO && cur_y == 0)
            trace_region = REG_DONE;
    endtask

    // work out the beats that one accepted command causes
    task automatic rasterize_cmd(input t_ellipse_cmd cmd);
        logic [63:0] rx64, ry64;
        t_pixel_beat done_beat;
        if (cmd.mode == MODE_START) begin
            // start: latch, set up region 1, emit the (0, ry) points
            rx64       = {54'b0, cmd.radius_x};
            ry64       = {54'b0, cmd.radius_y};
            center_x_q = cmd.center_x;
            center_y_q = cmd.center_y;
            color_q    = cmd.pen_color;
            rx_sq      = rx64 * rx64;
            ry_sq      = ry64 * ry64;
            cur_x      = '0;
            cur_y      = {22'b0, cmd.radius_y};
            cross_x    = '0;
            cross_y    = 2 * rx_sq * ry64;
            decision   = 4 * ry_sq - 4 * rx_sq * ry64 + rx_sq;
            trace_region = REG_ONE;
            emit_quad();
            settle_region();
        end else if (trace_region == REG_ONE) begin
            // region 1: x always steps, y steps when the midpoint is outside
            cur_x   = cur_x + 1;
            cross_x = cross_x + 2 * ry_sq;
            if (decision[63]) begin
                decision = decision + 4 * (ry_sq + cross_x);
            end else begin
                cur_y    = cur_y - 1;
                cross_y  = cross_y - 2 * rx_sq;
                decision = decision + 4 * (ry_sq + cross_x - cross_y);
            end
            emit_quad();
            settle_region();
        end else if (trace_region == REG_TWO) begin
            // region 2: y always steps, x steps when the midpoint is inside or on
            cur_y   = cur_y - 1;
            cross_y = cross_y - 2 * rx_sq;
            if (!decision[63] && decision != 0) begin
                decision = decision + 4 * (rx_sq - cross_y);
            end else begin
                cur_x    = cur_x + 1;
                cross_x  = cross_x + 2 * ry_sq;
                decision = decision + 4 * (rx_sq - cross_y + cross_x);
            end
            emit_quad();
            settle_region();
        end else begin
            // advance with nothing left to draw: a single empty, finished beat
            done_beat              = '0;
            done_beat.last_of_step = 1'b1;
            done_beat.finished     = 1'b1;
            expected_pixels.push_back(done_beat);
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    task automatic add_start(input logic [10:0] cx, input logic [10:0] cy,
                             input logic [9:0] rx, input logic [9:0] ry,
                             input logic [3:0] color, input bit hold);
        t_ellipse_cmd c;
        c.mode       = MODE_START;
        c.center_x   = cx;
        c.center_y   = cy;
        c.radius_x   = rx;
        c.radius_y   = ry;
        c.pen_color  = color;
        c.wait_empty = hold;
        cmd_queue.push_back(c);
    endtask

    // advance beats carry random payload, which the block ignores
    task automatic add_advances(input int count);
        t_ellipse_cmd c;
        repeat (count) begin
            c.mode       = MODE_ADVANCE;
            c.center_x   = 11'($urandom_range(0, 2047));
            c.center_y   = 11'($urandom_range(0, 2047));
            c.radius_x   = 10'($urandom_range(0, 1023));
            c.radius_y   = 10'($urandom_range(0, 1023));
            c.pen_color  = 4'($urandom_range(0, 15));
            c.wait_empty = 1'b0;
            cmd_queue.push_back(c);
        end
    endtask

    // ------------------------------------------------------------------
    // slave-side driver: bursts of beats separated by random gaps
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_proc
        logic fire;
        fire = s_axis_tvalid && s_axis_tready;
        if (fire)
            rasterize_cmd(active_cmd);
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || fire) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end else if (cmd_queue.size() == 0 ||
                         (cmd_queue[0].wait_empty && expected_pixels.size() != 0)) begin
                // out of commands, or holding off until all pixels are back
                s_axis_tvalid <= 1'b0;
            end else begin
                active_cmd = cmd_queue.pop_front();
                s_axis_tuser  <= active_cmd.mode;
                s_axis_tdata  <= {2'b00, active_cmd.pen_color, active_cmd.radius_y,
                                  active_cmd.radius_x, active_cmd.center_y,
                                  active_cmd.center_x};
                s_axis_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left = burst_left - 1;
                end else if ($urandom_range(0, 7) == 0) begin
                    // long stretch with no idling
                    burst_left = $urandom_range(40, 80);
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = $urandom_range(0, 10);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // master-side monitor and ready pattern
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [12:0] want,
                               input logic [12:0] got);
        if (want !== got) begin
            $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
            mismatch_count = mismatch_count + 1;
        end
    endtask

    always @(posedge i_clk) begin : monitor_proc
        t_pixel_beat got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            // tdata: pixel_x, pixel_y, pixel_color; tuser: pixel_valid, finished
            got.pixel_x      = m_axis_tdata[12:0];
            got.pixel_y      = m_axis_tdata[25:13];
            got.pixel_color  = m_axis_tdata[29:26];
            got.pixel_valid  = m_axis_tuser[0];
            got.finished     = m_axis_tuser[1];
            got.last_of_step = m_axis_tlast;
            if (expected_pixels.size() == 0) begin
                $error("pixel beat with nothing expected: tdata 'h%0h tuser 'h%0h",
                       m_axis_tdata, m_axis_tuser);
                mismatch_count = mismatch_count + 1;
            end else begin
                want = expected_pixels.pop_front();
                check_field("pixel_x",      want.pixel_x,      got.pixel_x);
                check_field("pixel_y",      want.pixel_y,      got.pixel_y);
                check_field("pixel_color",  13'(want.pixel_color),  13'(got.pixel_color));
                check_field("pixel_valid",  13'(want.pixel_valid),  13'(got.pixel_valid));
                check_field("last_of_step", 13'(want.last_of_step), 13'(got.last_of_step));
                check_field("finished",     13'(want.finished),     13'(got.finished));
            end
        end
        // ready pattern: runs of ready, short stalls, now and then long ready runs
        if (ready_left > 1) begin
            ready_left = ready_left - 1;
        end else if (!m_axis_tready) begin
            m_axis_tready <= 1'b1;
            ready_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
        end else begin
            m_axis_tready <= 1'b0;
            ready_left = $urandom_range(1, 10);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        logic [9:0] rx, ry;
        int         steps;

        // advance straight after reset: already finished
        add_advances(1);
        // small ellipse run to completion and past it
        add_start(11'd1024, 11'd1024, 10'd3, 10'd2, 4'd5, 1'b0);
        add_advances(8);
        // zero radii at the origin
        add_start(11'd0, 11'd0, 10'd0, 10'd0, 4'd0, 1'b0);
        add_advances(1);
        // largest radii and center, held until the pipe is empty, then abandoned
        add_start(11'd2047, 11'd2047, 10'd1023, 10'd1023, 4'd15, 1'b1);
        add_advances(2);
        // zero horizontal radius: straight into region 2
        add_start(11'd0, 11'd2047, 10'd0, 10'd4, 4'd9, 1'b0);
        add_advances(4);
        // zero vertical radius: only the start points
        add_start(11'd2047, 11'd0, 10'd6, 10'd0, 4'd10, 1'b0);
        add_advances(1);
        // very flat and very tall ellipses, coordinates wrap below zero
        add_start(11'd5, 11'd5, 10'd1023, 10'd1, 4'd3, 1'b0);
        add_advances(2);
        add_start(11'd5, 11'd5, 10'd1, 10'd1023, 4'd12, 1'b0);
        add_advances(2);

        // random part: mostly small ellipses drawn to the end, some cut short,
        // a few full-range ones abandoned after a handful of steps
        while (cmd_queue.size() < 520) begin
            if ($urandom_range(0, 11) == 0) begin
                rx    = 10'($urandom_range(0, 1023));
                ry    = 10'($urandom_range(0, 1023));
                steps = $urandom_range(0, 4);
            end else begin
                rx    = 10'($urandom_range(0, 20));
                ry    = 10'($urandom_range(0, 20));
                steps = ($urandom_range(0, 9) < 7) ? int'(rx) + int'(ry) + 2
                                                   : int'($urandom_range(0, rx + ry));
            end
            add_start(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)), rx, ry,
                      4'($urandom_range(0, 15)), $urandom_range(0, 19) == 0);
            add_advances(steps);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_pixels.size() != 0) begin
            $error("%0d expected pixel beats never arrived", expected_pixels.size());
            mismatch_count = mismatch_count + 1;
        end

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
